FILE: design/idr_pkg.sv
`timescale 1ns / 1ps

package idr_pkg;

    localparam int DataWidth = 32;
    localparam int CntWidth  = $clog2(DataWidth);

    typedef struct packed {
        logic [DataWidth-1:0] dividend;
        logic [DataWidth-1:0] divisor;
        logic                 func;
    } in_t;

    typedef struct packed {
        logic [DataWidth-1:0] quotient;
        logic [DataWidth-1:0] remainder;
        logic                 divide_by_zero;
    } out_t;

    typedef struct packed {
        logic busy;
        logic last;
    } core_stat_t;

    localparam logic FuncUnsigned = 1'b0;
    localparam logic FuncSigned   = 1'b1;

    function automatic logic [DataWidth-1:0] cond_negate(
        input logic [DataWidth-1:0] value,
        input logic                 negate
    );
        return negate ? (~value + DataWidth'(1)) : value;
    endfunction

endpackage

FILE: design/idr_core.sv
`timescale 1ns / 1ps

module idr_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [idr_pkg::DataWidth-1:0]   dividend_mag,
    input  logic [idr_pkg::DataWidth-1:0]   divisor_mag,
    output idr_pkg::core_stat_t             stat,
    output logic [idr_pkg::DataWidth-1:0]   quotient_mag,
    output logic [idr_pkg::DataWidth-1:0]   remainder_mag
);

    localparam int W = idr_pkg::DataWidth;
    localparam int C = idr_pkg::CntWidth;

    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] quo_reg, quo_next;
    logic [W-1:0] dvs_reg, dvs_next;
    logic [C-1:0] cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic [W:0]   rem_shift;
    logic [W:0]   diff;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[W-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend_mag;
            dvs_next  = divisor_mag;
            cnt_next  = C'(W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // restore on borrow, otherwise keep the difference
            if (diff[W]) begin
                rem_next = rem_shift[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end else begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - C'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.last     = busy_reg && (cnt_reg == '0);
    assign quotient_mag  = quo_reg;
    assign remainder_mag = rem_reg;

endmodule

FILE: design/integer_divide_remainder.sv
`timescale 1ns / 1ps

// 32-bit integer divider, signed (func = 1) or unsigned (func = 0), giving the
// quotient truncated toward zero and a remainder that carries the sign of the
// dividend. A zero divisor sets divide_by_zero and returns quotient 0 and the
// dividend as remainder. The operand magnitudes load into a radix-2 restoring
// shift-subtract unit at acceptance; that unit resolves one quotient bit per
// cycle, and the ST_FIX state then applies the signs as the result is written
// to the output register, waiting while that register still holds a result
// that has not been taken. The input is ready again once the result has
// entered the output register, so a new transaction can be accepted even
// while that result still waits to be taken.
module integer_divide_remainder (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  idr_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output idr_pkg::out_t m_data
);

    localparam int W = idr_pkg::DataWidth;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX
    } state_t;

    state_t              state_reg, state_next;
    logic                m_valid_reg, m_valid_next;
    idr_pkg::out_t       m_data_reg, m_data_next;

    logic [W-1:0]        dividend_reg;
    logic                n_neg_reg;
    logic                d_neg_reg;
    logic                dz_reg;

    logic                accept;
    logic                n_neg;
    logic                d_neg;
    logic [W-1:0]        dividend_mag;
    logic [W-1:0]        divisor_mag;
    idr_pkg::core_stat_t core_stat;
    logic [W-1:0]        quotient_mag;
    logic [W-1:0]        remainder_mag;
    logic                out_free;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign n_neg = (s_data.func == idr_pkg::FuncSigned) && s_data.dividend[W-1];
    assign d_neg = (s_data.func == idr_pkg::FuncSigned) && s_data.divisor[W-1];
    assign dividend_mag = idr_pkg::cond_negate(s_data.dividend, n_neg);
    assign divisor_mag  = idr_pkg::cond_negate(s_data.divisor, d_neg);

    idr_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (accept),
        .dividend_mag  (dividend_mag),
        .divisor_mag   (divisor_mag),
        .stat          (core_stat),
        .quotient_mag  (quotient_mag),
        .remainder_mag (remainder_mag)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            dividend_reg <= s_data.dividend;
            n_neg_reg    <= n_neg;
            d_neg_reg    <= d_neg;
            dz_reg       <= (s_data.divisor == '0);
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (core_stat.last) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                // hold until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (dz_reg) begin
                        m_data_next.quotient       = '0;
                        m_data_next.remainder      = dividend_reg;
                        m_data_next.divide_by_zero = 1'b1;
                    end else begin
                        m_data_next.quotient =
                            idr_pkg::cond_negate(quotient_mag, n_neg_reg ^ d_neg_reg);
                        m_data_next.remainder =
                            idr_pkg::cond_negate(remainder_mag, n_neg_reg);
                        m_data_next.divide_by_zero = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
